// File: sv/rls_two_param_estimator_top_macros.svh
// Assertion macros for the two-parameter RLS estimator.
`ifndef RLS_TWO_PARAM_ESTIMATOR_TOP_MACROS_SVH
`define RLS_TWO_PARAM_ESTIMATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RTPE_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rtpe check failed");
`define RTPE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rtpe check failed");
`else
`define RTPE_ASSERT_SAME(lbl, pre, post)
`define RTPE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: sv/rtpe_pkg.sv
// Types, constants and fixed-point helpers of the two-parameter RLS estimator.
package rtpe_pkg;
  typedef logic signed [47:0] q_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  localparam q_t   Q_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam q_t   Q_MIN     = 48'sh8000_0000_0000;
  localparam q_t   DEN_FLOOR = 48'sd17;
  localparam q_t   LAM_FLOOR = 48'sd256;
  localparam logic [48:0] MAG_OVF = 49'h1_0000_0000_0000;

  localparam logic [2:0] REG_FF   = 3'd0;
  localparam logic [2:0] REG_OFF  = 3'd1;
  localparam logic [2:0] REG_TH1  = 3'd2;
  localparam logic [2:0] REG_TH2  = 3'd3;
  localparam logic [2:0] REG_COV  = 3'd4;

  function automatic q_t sat49(input logic signed [48:0] v);
    q_t r;
    if (v > 49'sh0_7FFF_FFFF_FFFF) r = Q_MAX;
    else if (v < -49'sh0_8000_0000_0000) r = Q_MIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic q_t from_mag(input logic neg, input logic [48:0] m);
    q_t r;
    if (neg) begin
      if (m >= 49'h0_8000_0000_0000) r = Q_MIN;
      else r = -$signed(m[47:0]);
    end else begin
      if (m > 49'h0_7FFF_FFFF_FFFF) r = Q_MAX;
      else r = $signed(m[47:0]);
    end
    return r;
  endfunction

  function automatic logic [47:0] mag_of(input q_t a);
    logic [47:0] r;
    r = a[47] ? 48'(-a) : 48'(a);
    return r;
  endfunction

  function automatic logic [31:0] q_out(input q_t v);
    logic signed [39:0] s;
    logic [31:0] r;
    s = 40'(v >>> 8);
    if (s > 40'sh00_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (s < -40'sh00_8000_0000) r = 32'h8000_0000;
    else r = s[31:0];
    return r;
  endfunction
endpackage

// File: sv/rls_two_param_estimator_top.sv
// Two-parameter recursive least squares estimator with forgetting factor.
// Each word is worked through a 29-step program on one shared arithmetic unit: an add/sub
// is a single step, a multiply is operand setup then four 24x24 partial products, one per
// cycle, a divide is operand setup then one quotient bit per cycle for 72 quotient bits.
// The program has 13 multiplies, 5 divides and 11 add/sub steps; the result then waits on
// m_tready, and s_tready returns the cycle after it is taken. s_tready is low from
// acceptance until then, so no new word is accepted before the result is taken.
`include "rls_two_param_estimator_top_macros.svh"
module rls_two_param_estimator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // speed_feature[30:0], torque_sq_feature[61:31], measured_power[93:62],
  // mechanical_power[125:94], zero pad
  input  logic [127:0] s_tdata,
  // restart
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // first_estimate[31:0], second_estimate[63:32], prediction_error[95:64]
  output logic [95:0]  m_tdata
);
  import rtpe_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_OUT} state_t;

  localparam logic [4:0] PC_DEN  = 5'd9;
  localparam logic [4:0] PC_LAST = 5'd28;

  state_t      state;
  logic [4:0]  pc;
  logic [16:0] ff;
  logic [31:0] poff, th1_init, th2_init;
  logic [30:0] cov_init;
  q_t th1, th2, p11, p12, p22;
  q_t p1, p2, y, lam, t0, t1, s1, s2, den, k1, k2, e;

  logic [47:0] ua, ub;
  logic        neg;
  logic [1:0]  mcnt;
  logic [95:0] acc;
  logic [71:0] dv, quo;
  logic [47:0] rem, dsr;
  logic [6:0]  dcnt;

  op_t op;
  q_t  opa, opb, lamd, wb_val;
  logic wb_en;
  logic [23:0] ah, bh;
  logic [47:0] pp;
  logic [95:0] pp_sh, acc_sum;
  logic [48:0] r2;
  logic        ge;
  logic [71:0] quo_next;
  logic signed [33:0] ydiff;

  assign lamd = (lam < LAM_FLOOR) ? LAM_FLOOR : lam;

  always_comb begin
    op = OP_ADD; opa = t0; opb = t1;
    unique case (pc)
      5'd0:  begin op = OP_MUL; opa = p11; opb = p1; end
      5'd1:  begin op = OP_MUL; opa = p12; opb = p2; end
      5'd2:  begin op = OP_ADD; opa = t0;  opb = t1; end
      5'd3:  begin op = OP_MUL; opa = p12; opb = p1; end
      5'd4:  begin op = OP_MUL; opa = p22; opb = p2; end
      5'd5:  begin op = OP_ADD; opa = t0;  opb = t1; end
      5'd6:  begin op = OP_MUL; opa = p1;  opb = s1; end
      5'd7:  begin op = OP_MUL; opa = p2;  opb = s2; end
      5'd8:  begin op = OP_ADD; opa = t0;  opb = t1; end
      5'd9:  begin op = OP_ADD; opa = lam; opb = t0; end
      5'd10: begin op = OP_DIV; opa = s1;  opb = den; end
      5'd11: begin op = OP_DIV; opa = s2;  opb = den; end
      5'd12: begin op = OP_MUL; opa = th1; opb = p1; end
      5'd13: begin op = OP_MUL; opa = th2; opb = p2; end
      5'd14: begin op = OP_ADD; opa = t0;  opb = t1; end
      5'd15: begin op = OP_SUB; opa = y;   opb = t0; end
      5'd16: begin op = OP_MUL; opa = k1;  opb = e; end
      5'd17: begin op = OP_ADD; opa = th1; opb = t0; end
      5'd18: begin op = OP_MUL; opa = k2;  opb = e; end
      5'd19: begin op = OP_ADD; opa = th2; opb = t0; end
      5'd20: begin op = OP_MUL; opa = k1;  opb = s1; end
      5'd21: begin op = OP_SUB; opa = p11; opb = t0; end
      5'd22: begin op = OP_DIV; opa = t0;  opb = lamd; end
      5'd23: begin op = OP_MUL; opa = k1;  opb = s2; end
      5'd24: begin op = OP_SUB; opa = p12; opb = t0; end
      5'd25: begin op = OP_DIV; opa = t0;  opb = lamd; end
      5'd26: begin op = OP_MUL; opa = k2;  opb = s2; end
      5'd27: begin op = OP_SUB; opa = p22; opb = t0; end
      5'd28: begin op = OP_DIV; opa = t0;  opb = lamd; end
      default: begin op = OP_ADD; opa = t0; opb = t1; end
    endcase
  end

  always_comb begin
    ah = mcnt[0] ? ua[47:24] : ua[23:0];
    bh = mcnt[1] ? ub[47:24] : ub[23:0];
    pp = ah * bh;
    case (mcnt)
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
    acc_sum = acc + pp_sh;
    r2 = {rem, dv[71]};
    ge = r2 >= {1'b0, dsr};
    quo_next = {quo[70:0], ge};
  end

  always_comb begin
    wb_en = 1'b0;
    wb_val = t0;
    case (state)
      ST_EXEC: begin
        if (op == OP_ADD) begin
          wb_en = 1'b1; wb_val = sat49(49'(opa) + 49'(opb));
        end else if (op == OP_SUB) begin
          wb_en = 1'b1; wb_val = sat49(49'(opa) - 49'(opb));
        end
      end
      ST_MUL: begin
        wb_en = (mcnt == 2'd3);
        wb_val = from_mag(neg, (acc_sum[95:72] != 24'd0) ? MAG_OVF : {1'b0, acc_sum[71:24]});
      end
      ST_DIV: begin
        wb_en = (dcnt == 7'd71);
        wb_val = from_mag(neg, (quo_next[71:48] != 24'd0) ? MAG_OVF : {1'b0, quo_next[47:0]});
      end
      default: wb_en = 1'b0;
    endcase
  end

  assign ydiff = 34'(signed'(s_tdata[93:62])) - 34'(signed'(s_tdata[125:94]))
               - 34'(signed'(poff));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      ff       <= 17'd64881;
      poff     <= '0;
      th1_init <= '0;
      th2_init <= '0;
      cov_init <= 31'd65536000;
      th1      <= '0;
      th2      <= '0;
      p11      <= {9'd0, 31'd65536000, 8'd0};
      p22      <= {9'd0, 31'd65536000, 8'd0};
      p12      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FF:  ff <= cfg_wdata[16:0];
          REG_OFF: poff <= cfg_wdata;
          REG_TH1: th1_init <= cfg_wdata;
          REG_TH2: th2_init <= cfg_wdata;
          REG_COV: cov_init <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (wb_en) begin
        case (pc)
          5'd1, 5'd4, 5'd7, 5'd13: t1 <= wb_val;
          5'd2:  s1 <= wb_val;
          5'd5:  s2 <= wb_val;
          5'd9:  den <= (wb_val < DEN_FLOOR) ? DEN_FLOOR : wb_val;
          5'd10: k1 <= wb_val;
          5'd11: k2 <= wb_val;
          5'd15: e <= wb_val;
          5'd17: th1 <= wb_val;
          5'd19: th2 <= wb_val;
          5'd22: p11 <= wb_val;
          5'd25: p12 <= wb_val;
          5'd28: p22 <= wb_val;
          default: t0 <= wb_val;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            p1  <= {9'd0, s_tdata[30:0], 8'd0};
            p2  <= {9'd0, s_tdata[61:31], 8'd0};
            y   <= {{6{ydiff[33]}}, ydiff, 8'd0};
            lam <= {23'd0, ff, 8'd0};
            if (s_tuser) begin
              th1 <= {{8{th1_init[31]}}, th1_init, 8'd0};
              th2 <= {{8{th2_init[31]}}, th2_init, 8'd0};
              p11 <= {9'd0, cov_init, 8'd0};
              p22 <= {9'd0, cov_init, 8'd0};
              p12 <= '0;
            end
            pc    <= '0;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ua  <= mag_of(opa);
          ub  <= mag_of(opb);
          neg <= (op == OP_MUL) ? (opa[47] ^ opb[47]) : opa[47];
          dsr <= opb;
          dv  <= {mag_of(opa), 24'd0};
          acc <= '0;
          rem <= '0;
          quo <= '0;
          mcnt <= '0;
          dcnt <= '0;
          if (op == OP_MUL) state <= ST_MUL;
          else if (op == OP_DIV) state <= ST_DIV;
          else if (pc == PC_LAST) state <= ST_OUT;
          else pc <= pc + 5'd1;
        end
        ST_MUL: begin
          acc  <= acc_sum;
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            pc <= pc + 5'd1;
            state <= ST_EXEC;
          end
        end
        ST_DIV: begin
          rem  <= ge ? 48'(r2 - {1'b0, dsr}) : r2[47:0];
          dv   <= {dv[70:0], 1'b0};
          quo  <= quo_next;
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd71) begin
            if (pc == PC_LAST) state <= ST_OUT;
            else begin
              pc <= pc + 5'd1;
              state <= ST_EXEC;
            end
          end
        end
        ST_OUT: begin
          if (m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {q_out(e), q_out(th2), q_out(th1)};

  `RTPE_ASSERT_SAME(a_one_side, s_tready, !m_tvalid)
  `RTPE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `RTPE_ASSERT_SAME(a_den_floor, (state != ST_IDLE) && (pc > PC_DEN), den >= DEN_FLOOR)
  `RTPE_ASSERT_SAME(a_div_count, state == ST_DIV, dcnt <= 7'd71)
endmodule
